// ----- hdl/mkdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkdp_pkg
// Shared widths, opcodes and types for the multi-key debounce block.
// ----------------------------------------------------------------------------
package mkdp_pkg;

   localparam int LEVEL_W = 6;   // sampled key level bits per item
   localparam int CNT_W   = 8;   // run counter / threshold width
   localparam int EVENT_W = 3;   // event code width

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd20;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [EVENT_W-1:0] event_type;

   typedef struct packed {
      logic tick;   // accepted scan tick
      logic read;   // accepted read-and-clear
   } cmd_type;

endpackage
`default_nettype wire

// ----- hdl/multi_key_debounce_press_event.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_key_debounce_press_event
// Debounces NUM_KEYS active-low keys in parallel lanes and latches one
// press event, returned by a read item and reported on every tick.
//
// Channel   Dir   Handshake          Payload
// req       in    tvalid/tready      tuser: opcode, tdata: key_levels
// rsp       out   tvalid/tready      tdata: event_key
// csr       in    we                 wdata: debounce_ticks
//
// One item accepted per cycle while the queue is not full; its result enters the queue the next cycle.
// A two-entry output queue holds results; req_tready drops only when full.
// All lanes and the pending event update in the accepting cycle.
// Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
module multi_key_debounce_press_event #(
   parameter int NUM_KEYS = 6
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire        req_tuser,    // [0] opcode
   input  wire  [7:0] req_tdata,    // [5:0] key_levels, [7:6] zero
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,    // [2:0] event_key, [7:3] zero
   input  wire        csr_we,
   input  wire  [7:0] csr_wdata     // [7:0] debounce_ticks
);
   import mkdp_pkg::*;

   count_type         thr_ff;
   logic              accept;
   cmd_type           cmd;
   logic [NUM_KEYS-1:0] press;
   event_type         pending;
   event_type         result;

   event_type         slot0_ff, slot0_in;
   event_type         slot1_ff, slot1_in;
   logic [1:0]        cnt_ff, cnt_in, cnt_mid;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign cmd.tick = accept && (req_tuser == OP_TICK);
   assign cmd.read = accept && (req_tuser == OP_READ);

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      logic smp;
      if (k < LEVEL_W) begin : g_in
         assign smp = req_tdata[k];
      end else begin : g_zero
         assign smp = 1'b0;
      end
      mkdp_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .tick      (cmd.tick),
         .sample    (smp),
         .threshold (thr_ff),
         .press     (press[k])
      );
   end

   mkdp_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .press   (press),
      .pending (pending),
      .result  (result)
   );

   // output queue, slot0 is head
   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_mid  = cnt_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         cnt_mid  = cnt_ff - 2'd1;
      end
      cnt_in = cnt_mid;
      if (accept) begin
         if (cnt_mid == 2'd0) begin
            slot0_in = result;
         end else begin
            slot1_in = result;
         end
         cnt_in = cnt_mid + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {(8 - EVENT_W)'(0), slot0_ff};

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_read_clears : assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> (pending == '0))
      else $error("pending event not cleared by read");

   a_pending_holds : assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && (pending != '0)) |=> (pending == $past(pending)))
      else $error("pending event overwritten by tick");

   a_result_visible : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no result");

endmodule
`default_nettype wire

// ----- hdl/mkdp_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkdp_lane
// One key's debounce core: last sample, run counter and debounced level.
// Flags a debounced press (fall to 0) on the tick that accepts it.
// ----------------------------------------------------------------------------
module mkdp_lane (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     tick,
   input  wire                     sample,
   input  wire mkdp_pkg::count_type threshold,
   output logic                    press
);
   import mkdp_pkg::*;

   logic      last_ff, last_in;
   logic      deb_ff, deb_in;
   count_type cnt_ff, cnt_in;

   always_comb begin
      last_in = last_ff;
      deb_in  = deb_ff;
      cnt_in  = cnt_ff;
      press   = 1'b0;
      if (tick) begin
         if (sample == last_ff) begin
            if (cnt_ff < threshold) begin
               cnt_in = cnt_ff + count_type'(1);
            end
         end else begin
            cnt_in  = '0;
            last_in = sample;
         end
         if ((cnt_in == threshold) && (sample != deb_ff)) begin
            deb_in = sample;
            press  = ~sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b1;
         deb_ff  <= 1'b1;
         cnt_ff  <= '0;
      end else begin
         last_ff <= last_in;
         deb_ff  <= deb_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/mkdp_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkdp_merge
// Merges lane press flags: lowest key wins, latched into the pending event
// only when none is pending. Produces the result code for each item.
// ----------------------------------------------------------------------------
module mkdp_merge #(
   parameter int NUM_KEYS = 6
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire mkdp_pkg::cmd_type  cmd,
   input  wire [NUM_KEYS-1:0]      press,
   output mkdp_pkg::event_type     pending,
   output mkdp_pkg::event_type     result
);
   import mkdp_pkg::*;

   event_type pend_ff, pend_in;
   event_type sel;

   // code wraps to EVENT_W bits; a key whose code wraps to 0 never latches
   always_comb begin
      sel = '0;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (press[k] && (event_type'(k + 1) != '0)) begin
            sel = event_type'(k + 1);
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      result  = pend_ff;
      if (cmd.read) begin
         pend_in = '0;
      end else if (cmd.tick) begin
         if (pend_ff == '0) begin
            pend_in = sel;
         end
         result = pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   assign pending = pend_ff;

endmodule
`default_nettype wire
